[rtl/modular_power_core_assert.svh]
// modular_power_core_assert.svh: assertion macros for the modular power core
// used by the controller and datapath; empty bodies when SYNTH is defined
`ifndef MODULAR_POWER_CORE_ASSERT_SVH
`define MODULAR_POWER_CORE_ASSERT_SVH
`ifndef SYNTH
// property that must hold on every clock outside reset
`define MP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the next one
`define MP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define MP_ASSERT(lbl, clk, rstn, prop, msg)
`define MP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/mp_pkg.sv]
// mp_pkg: shared widths, types and constants of the modular power core
// no dependencies; used by every module of the block
`default_nettype none

package mp_pkg;

  // defaults of the top-level parameters
  localparam int unsigned MODULUS_DEF  = 1000000007;
  localparam int unsigned EXP_BITS_DEF = 63;

  // field widths
  localparam int BASE_W = 30;
  localparam int EXP_W  = 63;
  localparam int RES_W  = 30;

  // op field codes
  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // residue width (modulus below 2^31) and montgomery radix width
  localparam int OP_W   = 31;
  localparam int MONT_W = 32;

  // multiplier pipeline depth and wait counter
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] MUL_LAT = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_STEP,
    S_EXIT
  } mp_state_t;

  // which multiply pair the datapath feeds and writes back
  typedef enum logic [1:0] {
    MK_CONV,
    MK_STEP,
    MK_EXIT
  } mp_kind_t;

  typedef struct packed {
    logic     load;
    logic     write;
    mp_kind_t kind;
  } mp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_last;
  } mp_stat_t;

  // -m^-1 mod 2^32 for odd m, newton iteration doubling correct bits
  function automatic logic [MONT_W-1:0] mont_neg_inv(input logic [MONT_W-1:0] m);
    logic [MONT_W-1:0] inv;
    inv = m;
    for (int i = 0; i < 4; i++) begin
      inv = inv * (32'd2 - m * inv);
    end
    return 32'd0 - inv;
  endfunction

endpackage

`default_nettype wire

[rtl/modular_power_core.sv]
// Modular power core: result = base^exponent mod MODULUS by right-to-left
// square-and-multiply in montgomery form; op = 1 uses exponent MODULUS - 2
// (fermat inverse, zero maps to zero). One word is in work at a time. An
// accepted word is loaded, then its base is converted, then one step runs
// per exponent bit up to and including its highest set bit, then the result
// is converted back. Each conversion and step waits for the round trip
// through the 5-stage montgomery multiplier; squaring and accumulation run
// on two such units side by side. The result sits in an output register, so
// a new word is taken while the previous result waits.
// Depends on mp_pkg, mp_ctrl, mp_datapath and mp_montmul.
`default_nettype none

module modular_power_core #(
  parameter int unsigned MODULUS  = mp_pkg::MODULUS_DEF,
  parameter int unsigned EXP_BITS = mp_pkg::EXP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_op,
  input  wire logic [mp_pkg::BASE_W-1:0] in_base,
  input  wire logic [mp_pkg::EXP_W-1:0]  in_exponent,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [mp_pkg::RES_W-1:0]  out_result
);

  mp_pkg::mp_cmd_t  cmd;
  mp_pkg::mp_stat_t stat;

  // sequencer
  mp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic
  mp_datapath #(
    .MODULUS  (MODULUS),
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_op),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .stat        (stat),
    .result      (out_result)
  );

endmodule

`default_nettype wire

[rtl/mp_montmul.sv]
// mp_montmul: five-stage pipelined montgomery multiplier, radix 2^32
// depends on mp_pkg; y = a * b * 2^-32 mod MODULUS, fully reduced
`default_nettype none

module mp_montmul #(
  parameter int unsigned MODULUS = mp_pkg::MODULUS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [mp_pkg::OP_W-1:0] a,
  input  wire logic [mp_pkg::OP_W-1:0] b,
  output logic      [mp_pkg::OP_W-1:0] y
);

  localparam int PW  = 2 * mp_pkg::OP_W;
  localparam int MMW = mp_pkg::MONT_W + mp_pkg::OP_W;
  localparam int SW  = 2 * mp_pkg::MONT_W;

  localparam logic [mp_pkg::MONT_W-1:0] MOD32  = mp_pkg::MONT_W'(MODULUS);
  localparam logic [mp_pkg::OP_W-1:0]   MOD_OP = mp_pkg::OP_W'(MODULUS);
  localparam logic [mp_pkg::MONT_W-1:0] MP     = mp_pkg::mont_neg_inv(MOD32);

  logic [PW-1:0]             p_r;
  logic [PW-1:0]             t2_r;
  logic [PW-1:0]             t3_r;
  logic [mp_pkg::MONT_W-1:0] m_r;
  logic [MMW-1:0]            mm_r;
  logic [mp_pkg::MONT_W-1:0] u_r;
  logic [mp_pkg::OP_W-1:0]   y_r;
  logic [SW-1:0]             sum;

  // t + m * modulus has its low radix bits zero
  assign sum = SW'(t3_r) + SW'(mm_r);

  // product, quotient digit, correction product, shift, final subtract
  always_ff @(posedge clk) begin
    p_r  <= PW'(a) * PW'(b);
    m_r  <= p_r[mp_pkg::MONT_W-1:0] * MP;
    t2_r <= p_r;
    mm_r <= MMW'(m_r) * MMW'(MOD_OP);
    t3_r <= t2_r;
    u_r  <= sum[SW-1:mp_pkg::MONT_W];
    y_r  <= (u_r >= MOD32) ? mp_pkg::OP_W'(u_r - MOD32) : u_r[mp_pkg::OP_W-1:0];
  end

  assign y = y_r;

endmodule

`default_nettype wire

[rtl/mp_datapath.sv]
// mp_datapath: operand registers, exponent shifter and two montgomery units
// depends on mp_pkg and mp_montmul; driven by mp_ctrl commands
`default_nettype none

`include "modular_power_core_assert.svh"

module mp_datapath #(
  parameter int unsigned MODULUS  = mp_pkg::MODULUS_DEF,
  parameter int unsigned EXP_BITS = mp_pkg::EXP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mp_pkg::mp_cmd_t           cmd,
  input  wire logic                      in_op,
  input  wire logic [mp_pkg::BASE_W-1:0] in_base,
  input  wire logic [mp_pkg::EXP_W-1:0]  in_exponent,
  output mp_pkg::mp_stat_t               stat,
  output logic      [mp_pkg::RES_W-1:0]  result
);

  localparam int EW = (EXP_BITS > mp_pkg::OP_W) ? EXP_BITS : mp_pkg::OP_W;

  // montgomery constants: 2^32 mod m and 2^64 mod m
  localparam logic [63:0] MOD64 = 64'(MODULUS);
  localparam logic [63:0] R1_64 = (64'd1 << mp_pkg::MONT_W) % MOD64;
  localparam logic [63:0] R2_64 = (R1_64 * R1_64) % MOD64;
  localparam logic [mp_pkg::OP_W-1:0] R1      = R1_64[mp_pkg::OP_W-1:0];
  localparam logic [mp_pkg::OP_W-1:0] R2      = R2_64[mp_pkg::OP_W-1:0];
  localparam logic [mp_pkg::OP_W-1:0] MOD_OP  = mp_pkg::OP_W'(MODULUS);
  localparam logic [mp_pkg::OP_W-1:0] INV_EXP = mp_pkg::OP_W'(MODULUS - 2);
  localparam logic [mp_pkg::OP_W-1:0] ONE     = mp_pkg::OP_W'(1);

  logic [mp_pkg::BASE_W-1:0] base_r;
  logic [EW-1:0]             exp_r;
  logic [mp_pkg::OP_W-1:0]   acc_r;
  logic [mp_pkg::OP_W-1:0]   sq_r;
  logic [mp_pkg::RES_W-1:0]  res_r;

  logic [mp_pkg::OP_W-1:0] sq_a;
  logic [mp_pkg::OP_W-1:0] sq_b;
  logic [mp_pkg::OP_W-1:0] acc_b;
  logic [mp_pkg::OP_W-1:0] sq_y;
  logic [mp_pkg::OP_W-1:0] acc_y;

  // operand select for the squaring unit and the accumulator unit
  always_comb begin
    unique case (cmd.kind)
      mp_pkg::MK_CONV: begin
        sq_a  = mp_pkg::OP_W'(base_r);
        sq_b  = R2;
        acc_b = sq_r;
      end
      mp_pkg::MK_STEP: begin
        sq_a  = sq_r;
        sq_b  = sq_r;
        acc_b = sq_r;
      end
      mp_pkg::MK_EXIT: begin
        sq_a  = sq_r;
        sq_b  = sq_r;
        acc_b = ONE;
      end
      default: begin
        sq_a  = sq_r;
        sq_b  = sq_r;
        acc_b = sq_r;
      end
    endcase
  end

  mp_montmul #(.MODULUS(MODULUS)) u_sq_mul (
    .clk (clk),
    .a   (sq_a),
    .b   (sq_b),
    .y   (sq_y)
  );

  mp_montmul #(.MODULUS(MODULUS)) u_acc_mul (
    .clk (clk),
    .a   (acc_r),
    .b   (acc_b),
    .y   (acc_y)
  );

  // load a new word, then write back one multiply pair at a time
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base;
      exp_r  <= (in_op == mp_pkg::OP_INVERSE) ? EW'(INV_EXP)
                                              : EW'(in_exponent[EXP_BITS-1:0]);
      acc_r  <= R1;
    end
    if (cmd.write) begin
      case (cmd.kind)
        mp_pkg::MK_CONV: sq_r <= sq_y;
        mp_pkg::MK_STEP: begin
          sq_r  <= sq_y;
          exp_r <= exp_r >> 1;
          if (exp_r[0]) begin
            acc_r <= acc_y;
          end
        end
        mp_pkg::MK_EXIT: res_r <= acc_y[mp_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.exp_zero = (exp_r == '0);
  assign stat.exp_last = (exp_r[EW-1:1] == '0);
  assign result        = res_r;

  // residues written back stay fully reduced
  `MP_ASSERT_NEXT(a_sq_reduced, clk, rst_n, cmd.write, sq_r < MOD_OP, "square out of range")
  `MP_ASSERT_NEXT(a_acc_reduced, clk, rst_n, cmd.write, acc_r < MOD_OP, "accumulator out of range")
  // each step consumes exactly one exponent bit
  `MP_ASSERT_NEXT(a_exp_shift, clk, rst_n, cmd.write && cmd.kind == mp_pkg::MK_STEP,
                  exp_r == ($past(exp_r) >> 1), "exponent shift slip")

endmodule

`default_nettype wire

[rtl/mp_ctrl.sv]
// mp_ctrl: sequencer of the modular power core and output word handshake
// depends on mp_pkg; commands mp_datapath and reads its exponent status
`default_nettype none

`include "modular_power_core_assert.svh"

module mp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire mp_pkg::mp_stat_t stat,
  output mp_pkg::mp_cmd_t       cmd
);

  mp_pkg::mp_state_t             state_r;
  mp_pkg::mp_state_t             state_nxt;
  logic [mp_pkg::CNT_W-1:0]      cnt_r;
  logic [mp_pkg::CNT_W-1:0]      cnt_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          done;
  logic                          out_free;

  assign done     = (cnt_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mp_pkg::S_IDLE: if (in_valid) state_nxt = mp_pkg::S_CONV;
      mp_pkg::S_CONV: if (done) begin
        state_nxt = stat.exp_zero ? mp_pkg::S_EXIT : mp_pkg::S_STEP;
      end
      mp_pkg::S_STEP: if (done) begin
        state_nxt = stat.exp_last ? mp_pkg::S_EXIT : mp_pkg::S_STEP;
      end
      mp_pkg::S_EXIT: if (done && out_free) state_nxt = mp_pkg::S_IDLE;
      default: state_nxt = mp_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.load  = 1'b0;
    cmd.write = 1'b0;
    cmd.kind  = mp_pkg::MK_CONV;
    unique case (state_r)
      mp_pkg::S_IDLE: cmd.load = in_valid;
      mp_pkg::S_CONV: cmd.write = done;
      mp_pkg::S_STEP: begin
        cmd.kind  = mp_pkg::MK_STEP;
        cmd.write = done;
      end
      mp_pkg::S_EXIT: begin
        cmd.kind  = mp_pkg::MK_EXIT;
        cmd.write = done && out_free;
      end
      default: ;
    endcase
  end

  // pipeline wait counter, reloaded whenever operands change
  always_comb begin
    if (state_r == mp_pkg::S_IDLE || cmd.write) begin
      cnt_nxt = mp_pkg::MUL_LAT;
    end else if (done) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == mp_pkg::S_EXIT && cmd.write) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mp_pkg::S_IDLE;
      cnt_r       <= mp_pkg::MUL_LAT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != mp_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // an accepted word always starts with the base conversion
  `MP_ASSERT_NEXT(a_accept_conv, clk, rst_n, in_valid && !in_stall,
                  state_r == mp_pkg::S_CONV && cnt_r == mp_pkg::MUL_LAT, "accept without conv")
  // a finished result always lands in the output register
  `MP_ASSERT_NEXT(a_exit_out, clk, rst_n, state_r == mp_pkg::S_EXIT && cmd.write,
                  out_valid_r && state_r == mp_pkg::S_IDLE, "result lost")
  // wait counter never exceeds the multiplier depth
  `MP_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= mp_pkg::MUL_LAT, "wait counter overrun")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// tb: self-checking testbench for modular_power_core (base^exponent mod prime)
// depends on mp_pkg and the core; a small tracker class predicts and checks every word
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // widths and codes taken from the package
  localparam int RES_W  = mp_pkg::RES_W;
  localparam int BASE_W = mp_pkg::BASE_W;
  localparam int EXP_W  = mp_pkg::EXP_W;

  localparam logic OP_POWER   = mp_pkg::OP_POWER;
  localparam logic OP_INVERSE = mp_pkg::OP_INVERSE;

  localparam longint unsigned PRIME = longint'(mp_pkg::MODULUS_DEF);
  localparam int RANDOM_PER_PHASE  = 440;
  localparam int DRAIN_CYCLES      = 400;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // predicted residues in order of acceptance, checked against the result port
  class power_tracker;
    logic [RES_W-1:0] pending_residues[$];
    int unsigned      error_count;
    int unsigned      results_checked;

    // right-to-left square-and-multiply over the exponent
    function automatic logic [RES_W-1:0] predict_residue(logic op, logic [BASE_W-1:0] base,
                                                         logic [EXP_W-1:0] exponent);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned e;
      acc = 64'd1 % PRIME;
      sq  = longint'(base) % PRIME;
      if (op == OP_INVERSE) begin
        e = PRIME - 64'd2;
      end else begin
        e = {1'b0, exponent} & ((64'd1 << mp_pkg::EXP_BITS_DEF) - 64'd1);
      end
      while (e != 0) begin
        if (e[0]) begin
          acc = (acc * sq) % PRIME;
        end
        sq = (sq * sq) % PRIME;
        e  = e >> 1;
      end
      return acc[RES_W-1:0];
    endfunction

    function void note_word(logic op, logic [BASE_W-1:0] base, logic [EXP_W-1:0] exponent);
      pending_residues.push_back(predict_residue(op, base, exponent));
    endfunction

    function void check_word(logic [RES_W-1:0] result);
      logic [RES_W-1:0] want;
      if (pending_residues.size() == 0) begin
        $error("result word %0d arrived with nothing outstanding", result);
        error_count++;
      end else begin
        want = pending_residues.pop_front();
        results_checked++;
        if (result !== want) begin
          $error("mismatch on field result: expected %0d, actual %0d", want, result);
          error_count++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = OP_POWER;
  logic [BASE_W-1:0]   in_base = '0;
  logic [EXP_W-1:0]    in_exponent = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RES_W-1:0]    out_result;

  idle_mode_t   idle_mode = IDLE_NONE;
  power_tracker tracker = new();
  int unsigned  words_sent;
  int unsigned  inverse_words;

  modular_power_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  always #2 clk = ~clk;

  // watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      tracker.note_word(in_op, in_base, in_exponent);
      words_sent++;
      if (in_op == OP_INVERSE) begin
        inverse_words++;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_word(out_result);
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 83);
      IDLE_BOTH:     out_stall <= ($urandom_range(99) < 6);
      default:       out_stall <= 1'b0;
    endcase
  end

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 83;
      IDLE_BOTH:   return $urandom_range(99) < 6;
      default:     return 1'b0;
    endcase
  endfunction

  // entered and left just after a falling edge; holds the word until taken
  task automatic send_word(input logic op, input logic [BASE_W-1:0] base,
                           input logic [EXP_W-1:0] exponent);
    while (sender_rests()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_base     <= base;
    in_exponent <= exponent;
    do begin
      @(posedge clk);
    end while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // mostly short exponents keep the run fast, a few span all bits
  function automatic logic [EXP_W-1:0] random_exponent();
    int unsigned     nbits;
    logic [63:0]     raw;
    nbits = ($urandom_range(99) < 88) ? $urandom_range(20) : $urandom_range(EXP_W);
    raw   = {$urandom, $urandom};
    if (nbits == 0) begin
      return '0;
    end
    raw = raw & ((64'd1 << nbits) - 64'd1);
    return raw[EXP_W-1:0];
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    case ($urandom_range(9))
      0:       return '0;
      1:       return BASE_W'(1);
      2:       return BASE_W'(PRIME - 1);
      3:       return BASE_W'($urandom_range((1 << BASE_W) - 1, mp_pkg::MODULUS_DEF));
      default: return BASE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_word();
    logic op;
    op = ($urandom_range(99) < 30) ? OP_INVERSE : OP_POWER;
    send_word(op, random_base(), random_exponent());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words: field extremes, both operations and the corner cases
    send_word(OP_POWER, '0, '0);                              // zero exponent, zero base
    send_word(OP_POWER, BASE_W'(5), '0);                      // zero exponent
    send_word(OP_POWER, '0, EXP_W'(5));
    send_word(OP_POWER, BASE_W'(1), '1);
    send_word(OP_POWER, '1, '1);                              // both fields all ones
    send_word(OP_POWER, BASE_W'(PRIME - 1), EXP_W'(1));
    send_word(OP_POWER, BASE_W'(PRIME - 1), EXP_W'(2));
    send_word(OP_POWER, BASE_W'(PRIME), '0);                  // base equal to modulus
    send_word(OP_POWER, BASE_W'(PRIME), EXP_W'(3));
    send_word(OP_POWER, BASE_W'(PRIME + 1), 63'h5555_5555_5555_5555);
    send_word(OP_POWER, BASE_W'(2), EXP_W'(PRIME - 1));       // fermat check
    send_word(OP_POWER, BASE_W'(12345), 63'h4000_0000_0000_0000);
    send_word(OP_POWER, BASE_W'(987654321), 63'h2aaa_aaaa_aaaa_aaaa);
    send_word(OP_INVERSE, '0, '1);                            // inverse of zero
    send_word(OP_INVERSE, BASE_W'(1), '0);
    send_word(OP_INVERSE, BASE_W'(2), '1);
    send_word(OP_INVERSE, BASE_W'(PRIME - 1), EXP_W'(7));
    send_word(OP_INVERSE, BASE_W'(PRIME), '0);                // reduces to zero
    send_word(OP_INVERSE, '1, 63'h1234_5678_9abc_def0);

    // random words under each back-pressure pattern
    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      idle_mode = idle_mode_t'(m);
      repeat (RANDOM_PER_PHASE) send_random_word();
    end
    in_valid  <= 1'b0;
    idle_mode = IDLE_NONE;

    while (tracker.pending_residues.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d inverse) over four back-pressure patterns",
             words_sent, inverse_words);
    $display("%0d results checked, %0d errors", tracker.results_checked, tracker.error_count);
    if (tracker.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", tracker.pending_residues.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
